@@ rtl/scalar_kalman_outlier_filter_unit_macros.svh @@
// Assertion macros shared by the checker of the scalar Kalman outlier filter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SCALAR_KALMAN_OUTLIER_FILTER_UNIT_MACROS_SVH
`define SCALAR_KALMAN_OUTLIER_FILTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKOF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/skof_pkg.sv @@
// Shared types and constants of the scalar Kalman outlier filter.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package skof_pkg;

    // Fixed-point constants.
    localparam int GAIN_BITS       = 17;
    localparam int COV_WIDTH       = 32;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int OUT_WIDTH       = 16;
    localparam int PCT_WIDTH       = 7;
    localparam int STEP_WIDTH      = 4;
    localparam int COUNT_WIDTH     = 5;

    localparam logic [GAIN_BITS-1:0]   GAIN_ONE   = 17'h10000;
    localparam logic [GAIN_BITS-1:0]   PCT_SCALE  = 17'd100;
    localparam logic [COUNT_WIDTH-1:0] DIV_COUNT  = 5'd17;
    localparam logic [PCT_WIDTH-1:0]   PCT_RESET  = 7'd20;
    localparam logic [COV_WIDTH-1:0]   PV_RESET   = 32'd655;
    localparam logic [COV_WIDTH-1:0]   MV_RESET   = 32'd65536;
    localparam logic [COV_WIDTH-1:0]   COV_RESET  = 32'd65536;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PROCESS_VARIANCE     = 3'd0,
        REG_MEASUREMENT_VARIANCE = 3'd1,
        REG_INITIAL_ESTIMATE     = 3'd2,
        REG_INITIAL_COVARIANCE   = 3'd3,
        REG_OUTLIER_PERCENT      = 3'd4
    } cfg_reg_t;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT_IN,
        OP_SEED,
        OP_PREDICT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_COV,
        OP_COV_UPD,
        OP_MUL_EST,
        OP_EST_UPD,
        OP_MUL_DEV,
        OP_MUL_THR,
        OP_COMPARE,
        OP_OUT
    } op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SEEDED,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [STEP_WIDTH-1:0] step_t;

    // One microcode word.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Status flags that the datapath returns to the sequencer.
    typedef struct packed {
        logic seeded;
        logic div_more;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/scalar_kalman_outlier_filter_unit.sv @@
// Scalar Kalman filter with outlier reset. One request carries one Q8.8
// reading; one result returns the filtered Q8.8 value, the outlier flag and
// the Q1.16 gain. The first request after reset also seeds the state from
// configuration. The 17 iterations of the restoring gain divider make up most
// of the work on a request, and a new request is taken only once the last one
// is through. The result waits in an output register, so a stalled result
// delays the next request only once the following result is ready.
// Configuration is to be written only while idle; the block does not enforce it.
// Depends on skof_pkg, skof_seq, skof_dp and skof_mul.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_outlier_filter_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [skof_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [skof_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [SAMPLE_WIDTH-1:0]              sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [skof_pkg::OUT_WIDTH-1:0]            filtered,
    output logic                                      outlier_reset,
    output logic [skof_pkg::GAIN_BITS-1:0]            gain
);

    skof_pkg::op_t        op;
    skof_pkg::dp_status_t status;
    logic                 in_accept;

    // A request is taken only on the idle step of the program.
    assign in_stall  = (op != skof_pkg::OP_WAIT_IN);
    assign in_accept = in_valid && !in_stall;

    skof_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .status  (status),
        .op      (op)
    );

    skof_dp #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (in_accept),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered     (filtered),
        .outlier_reset(outlier_reset),
        .gain         (gain)
    );

endmodule

`default_nettype wire

@@ rtl/skof_mul.sv @@
// Registered unsigned multiplier shared by all products of the filter.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module skof_mul #(
    parameter int A_WIDTH = 17,
    parameter int B_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [A_WIDTH-1:0]         a,
    input  wire logic [B_WIDTH-1:0]         b,
    output logic      [A_WIDTH+B_WIDTH-1:0] product
);

    logic [A_WIDTH+B_WIDTH-1:0] prod_reg;

    // The product is captured only on a multiply step and held otherwise.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (A_WIDTH+B_WIDTH)'(a) * (A_WIDTH+B_WIDTH)'(b);
        end
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

@@ rtl/skof_dp.sv @@
// Datapath of the scalar Kalman outlier filter: configuration, filter state,
// serial gain divider, shared multiplier and output register. Uses skof_pkg and skof_mul.
`timescale 1ns / 1ps
`default_nettype none

module skof_dp #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire skof_pkg::op_t                        op,
    output skof_pkg::dp_status_t                      status,
    input  wire logic                                 cfg_we,
    input  wire logic [skof_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [skof_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                                 in_accept,
    input  wire logic [SAMPLE_WIDTH-1:0]              sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [skof_pkg::OUT_WIDTH-1:0]            filtered,
    output logic                                      outlier_reset,
    output logic [skof_pkg::GAIN_BITS-1:0]            gain
);

    localparam int EW = SAMPLE_WIDTH + 8;
    localparam int MW = (EW > skof_pkg::COV_WIDTH) ? EW : skof_pkg::COV_WIDTH;
    localparam int PW = skof_pkg::GAIN_BITS + MW;
    localparam int CW = skof_pkg::COV_WIDTH;
    localparam int GW = skof_pkg::GAIN_BITS;
    localparam int OW = skof_pkg::OUT_WIDTH;

    // Configuration registers.
    logic [CW-1:0]                   pv_reg, pv_next;
    logic [CW-1:0]                   mv_reg, mv_next;
    logic [15:0]                     init_est_reg, init_est_next;
    logic [CW-1:0]                   init_cov_reg, init_cov_next;
    logic [skof_pkg::PCT_WIDTH-1:0]  pct_reg, pct_next;

    // Filter state and working registers.
    logic                            seeded_reg, seeded_next;
    logic [EW-1:0]                   est_reg, est_next;
    logic [CW-1:0]                   cov_reg, cov_next;
    logic [EW-1:0]                   x_reg, x_next;
    logic [CW-1:0]                   pc_reg, pc_next;
    logic [CW:0]                     den_reg, den_next;
    logic [CW+1:0]                   rem_reg, rem_next;
    logic [GW-1:0]                   gain_reg, gain_next;
    logic [skof_pkg::COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                            dir_reg, dir_next;
    logic [PW-1:0]                   cmp_reg, cmp_next;
    logic [OW-1:0]                   res_filt_reg, res_filt_next;
    logic                            res_out_reg, res_out_next;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    logic [OW-1:0]                   filtered_reg, filtered_next;
    logic                            outlier_reg, outlier_next;
    logic [GW-1:0]                   gain_out_reg, gain_out_next;

    // Multiplier operands and product.
    logic                            mul_en;
    logic [GW-1:0]                   mul_a;
    logic [MW-1:0]                   mul_b;
    logic [PW-1:0]                   prod;

    // Combinational helpers.
    logic                            x_ge_est;
    logic [EW-1:0]                   abs_diff;
    logic [CW:0]                     pc_sum;
    logic [CW:0]                     den_sum;
    logic                            div_ge;
    logic [CW+1:0]                   div_rem;
    logic [PW:0]                     dn_sum;
    logic [EW-1:0]                   est_up;
    logic [EW-1:0]                   est_dn;
    logic [EW:0]                     est_round;
    logic [SAMPLE_WIDTH:0]           filt_wide;
    logic [SAMPLE_WIDTH-1:0]         filt_sat;
    logic                            out_busy;
    logic                            is_outlier;

    skof_mul #(
        .A_WIDTH(GW),
        .B_WIDTH(MW)
    ) u_mul (
        .clk    (clk),
        .en     (mul_en),
        .a      (mul_a),
        .b      (mul_b),
        .product(prod)
    );

    // Distance between the reading and the estimate, used twice per request.
    assign x_ge_est = (x_reg >= est_reg);
    assign abs_diff = x_ge_est ? (x_reg - est_reg) : (est_reg - x_reg);

    // Saturating covariance prediction and exact gain denominator.
    assign pc_sum  = {1'b0, cov_reg} + {1'b0, pv_reg};
    assign den_sum = {1'b0, pc_reg} + {1'b0, mv_reg};

    // One restoring division step; a zero denominator yields zero bits.
    assign div_ge  = (den_reg != '0) && (rem_reg >= {1'b0, den_reg});
    assign div_rem = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // Estimate moves toward the reading: floor going up, ceiling going down.
    assign dn_sum = {1'b0, prod} + (PW+1)'(16'hFFFF);
    assign est_up = est_reg + EW'(prod >> 16);
    assign est_dn = est_reg - EW'(dn_sum >> 16);

    // Round half up to eight fraction bits and saturate to the sample range.
    assign est_round = {1'b0, est_reg} + (EW+1)'(128);
    assign filt_wide = est_round[EW:8];
    assign filt_sat  = filt_wide[SAMPLE_WIDTH] ? '1 : filt_wide[SAMPLE_WIDTH-1:0];

    // Deviation times one hundred against percent times the reading.
    assign is_outlier = (cmp_reg > prod);

    assign out_busy = out_valid_reg && out_stall;

    // Multiplier operand selection.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (op)
            skof_pkg::OP_MUL_COV:
            begin
                mul_en = 1'b1;
                mul_a  = skof_pkg::GAIN_ONE - gain_reg;
                mul_b  = MW'(pc_reg);
            end
            skof_pkg::OP_MUL_EST:
            begin
                mul_en = 1'b1;
                mul_a  = gain_reg;
                mul_b  = MW'(abs_diff);
            end
            skof_pkg::OP_MUL_DEV:
            begin
                mul_en = 1'b1;
                mul_a  = skof_pkg::PCT_SCALE;
                mul_b  = MW'(abs_diff);
            end
            skof_pkg::OP_MUL_THR:
            begin
                mul_en = 1'b1;
                mul_a  = GW'(pct_reg);
                mul_b  = MW'(x_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Next-state logic for configuration, state and output.
    always_comb
    begin
        pv_next        = pv_reg;
        mv_next        = mv_reg;
        init_est_next  = init_est_reg;
        init_cov_next  = init_cov_reg;
        pct_next       = pct_reg;
        seeded_next    = seeded_reg;
        est_next       = est_reg;
        cov_next       = cov_reg;
        x_next         = x_reg;
        pc_next        = pc_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        gain_next      = gain_reg;
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        cmp_next       = cmp_reg;
        res_filt_next  = res_filt_reg;
        res_out_next   = res_out_reg;
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;
        outlier_next   = outlier_reg;
        gain_out_next  = gain_out_reg;

        // Configuration writes; unknown indexes are ignored.
        if (cfg_we)
        begin
            case (cfg_index)
                skof_pkg::REG_PROCESS_VARIANCE:     pv_next = cfg_data;
                skof_pkg::REG_MEASUREMENT_VARIANCE: mv_next = cfg_data;
                skof_pkg::REG_INITIAL_ESTIMATE:     init_est_next = cfg_data[15:0];
                skof_pkg::REG_INITIAL_COVARIANCE:   init_cov_next = cfg_data;
                skof_pkg::REG_OUTLIER_PERCENT:
                    pct_next = cfg_data[skof_pkg::PCT_WIDTH-1:0];
                default:
                begin
                    pv_next = pv_reg;
                end
            endcase
        end

        // The output register empties when the result is taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Capture the reading as Q.16.
        if (in_accept)
        begin
            x_next = {sample, 8'b0};
        end

        case (op)
            skof_pkg::OP_SEED:
            begin
                est_next    = EW'({init_est_reg, 8'b0});
                cov_next    = init_cov_reg;
                seeded_next = 1'b1;
            end
            skof_pkg::OP_PREDICT:
            begin
                pc_next = pc_sum[CW] ? '1 : pc_sum[CW-1:0];
            end
            skof_pkg::OP_DIV_INIT:
            begin
                den_next  = den_sum;
                rem_next  = (CW+2)'(pc_reg);
                gain_next = '0;
                cnt_next  = skof_pkg::DIV_COUNT;
            end
            skof_pkg::OP_DIV_STEP:
            begin
                rem_next  = {div_rem[CW:0], 1'b0};
                gain_next = {gain_reg[GW-2:0], div_ge};
                cnt_next  = cnt_reg - (skof_pkg::COUNT_WIDTH)'(1);
            end
            skof_pkg::OP_COV_UPD:
            begin
                cov_next = prod[CW+15:16];
            end
            skof_pkg::OP_MUL_EST:
            begin
                dir_next = x_ge_est;
            end
            skof_pkg::OP_EST_UPD:
            begin
                est_next = dir_reg ? est_up : est_dn;
            end
            skof_pkg::OP_MUL_THR:
            begin
                cmp_next = prod;
            end
            skof_pkg::OP_COMPARE:
            begin
                res_out_next = is_outlier;
                if (is_outlier)
                begin
                    est_next      = x_reg;
                    res_filt_next = OW'(x_reg[EW-1:8]);
                end
                else
                begin
                    res_filt_next = OW'(filt_sat);
                end
            end
            skof_pkg::OP_OUT:
            begin
                // Load the result only once the output register is free.
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    filtered_next  = res_filt_reg;
                    outlier_next   = res_out_reg;
                    gain_out_next  = gain_reg;
                end
            end
            default:
            begin
                seeded_next = seeded_reg;
            end
        endcase
    end

    // Control, filter state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= skof_pkg::PV_RESET;
            mv_reg        <= skof_pkg::MV_RESET;
            init_est_reg  <= '0;
            init_cov_reg  <= skof_pkg::COV_RESET;
            pct_reg       <= skof_pkg::PCT_RESET;
            seeded_reg    <= 1'b0;
            est_reg       <= '0;
            cov_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg        <= pv_next;
            mv_reg        <= mv_next;
            init_est_reg  <= init_est_next;
            init_cov_reg  <= init_cov_next;
            pct_reg       <= pct_next;
            seeded_reg    <= seeded_next;
            est_reg       <= est_next;
            cov_reg       <= cov_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        pc_reg       <= pc_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        gain_reg     <= gain_next;
        dir_reg      <= dir_next;
        cmp_reg      <= cmp_next;
        res_filt_reg <= res_filt_next;
        res_out_reg  <= res_out_next;
        filtered_reg <= filtered_next;
        outlier_reg  <= outlier_next;
        gain_out_reg <= gain_out_next;
    end

    assign status.seeded   = seeded_reg;
    assign status.div_more = (cnt_reg != 5'd1);
    assign status.out_busy = out_busy;

    assign out_valid     = out_valid_reg;
    assign filtered      = filtered_reg;
    assign outlier_reset = outlier_reg;
    assign gain          = gain_out_reg;

endmodule

`default_nettype wire

@@ rtl/skof_seq.sv @@
// Microcode sequencer of the scalar Kalman outlier filter: program ROM,
// step counter and conditional jumps. Uses skof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skof_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire skof_pkg::dp_status_t status,
    output skof_pkg::op_t             op
);

    // Step addresses of the program.
    localparam skof_pkg::step_t S_IDLE   = 4'd0;
    localparam skof_pkg::step_t S_CHECK  = 4'd1;
    localparam skof_pkg::step_t S_SEED   = 4'd2;
    localparam skof_pkg::step_t S_PRED   = 4'd3;
    localparam skof_pkg::step_t S_DIVI   = 4'd4;
    localparam skof_pkg::step_t S_DIVS   = 4'd5;
    localparam skof_pkg::step_t S_MULC   = 4'd6;
    localparam skof_pkg::step_t S_COV    = 4'd7;
    localparam skof_pkg::step_t S_MULE   = 4'd8;
    localparam skof_pkg::step_t S_EST    = 4'd9;
    localparam skof_pkg::step_t S_MULD   = 4'd10;
    localparam skof_pkg::step_t S_MULT   = 4'd11;
    localparam skof_pkg::step_t S_CMP    = 4'd12;
    localparam skof_pkg::step_t S_OUT    = 4'd13;
    localparam skof_pkg::step_t S_DONE   = 4'd14;

    skof_pkg::step_t      step_reg, step_next;
    skof_pkg::ctrl_word_t word;
    logic                 take;

    // Program ROM: a jump is taken when its condition holds, else the next step follows.
    function automatic skof_pkg::ctrl_word_t microcode(input skof_pkg::step_t s);
        skof_pkg::ctrl_word_t w;
        w.op     = skof_pkg::OP_NOP;
        w.cond   = skof_pkg::COND_NEVER;
        w.target = S_IDLE;
        case (s)
            S_IDLE:
            begin
                w.op     = skof_pkg::OP_WAIT_IN;
                w.cond   = skof_pkg::COND_NO_INPUT;
                w.target = S_IDLE;
            end
            S_CHECK:
            begin
                w.cond   = skof_pkg::COND_SEEDED;
                w.target = S_PRED;
            end
            S_SEED: w.op = skof_pkg::OP_SEED;
            S_PRED: w.op = skof_pkg::OP_PREDICT;
            S_DIVI: w.op = skof_pkg::OP_DIV_INIT;
            S_DIVS:
            begin
                w.op     = skof_pkg::OP_DIV_STEP;
                w.cond   = skof_pkg::COND_DIV_MORE;
                w.target = S_DIVS;
            end
            S_MULC: w.op = skof_pkg::OP_MUL_COV;
            S_COV:  w.op = skof_pkg::OP_COV_UPD;
            S_MULE: w.op = skof_pkg::OP_MUL_EST;
            S_EST:  w.op = skof_pkg::OP_EST_UPD;
            S_MULD: w.op = skof_pkg::OP_MUL_DEV;
            S_MULT: w.op = skof_pkg::OP_MUL_THR;
            S_CMP:  w.op = skof_pkg::OP_COMPARE;
            S_OUT:
            begin
                w.op     = skof_pkg::OP_OUT;
                w.cond   = skof_pkg::COND_OUT_BUSY;
                w.target = S_OUT;
            end
            S_DONE:
            begin
                w.cond   = skof_pkg::COND_ALWAYS;
                w.target = S_IDLE;
            end
            default:
            begin
                w.cond   = skof_pkg::COND_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    assign word = microcode(step_reg);
    assign op   = word.op;

    // Jump condition evaluation.
    always_comb
    begin
        case (word.cond)
            skof_pkg::COND_NEVER:    take = 1'b0;
            skof_pkg::COND_ALWAYS:   take = 1'b1;
            skof_pkg::COND_NO_INPUT: take = !in_valid;
            skof_pkg::COND_SEEDED:   take = status.seeded;
            skof_pkg::COND_DIV_MORE: take = status.div_more;
            skof_pkg::COND_OUT_BUSY: take = status.out_busy;
            default:                 take = 1'b1;
        endcase
        step_next = take ? word.target : (step_reg + skof_pkg::step_t'(1));
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/skof_checker.sv @@
// Port-level checker of the scalar Kalman outlier filter, bound to the top level.
// Depends on the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "scalar_kalman_outlier_filter_unit_macros.svh"

module skof_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] filtered,
    input wire logic        outlier_reset,
    input wire logic [16:0] gain
);

    // A stalled result holds its payload.
    `SKOF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(filtered) && $stable(outlier_reset) && $stable(gain), "stalled result changed")

    // The gain never exceeds one.
    `SKOF_ASSERT_SAME(a_gain_range, out_valid, (gain[16] == 1'b0) || (gain[15:0] == 16'h0), "gain above one")

    // After taking a request the block works on it before taking another.
    `SKOF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request taken while busy")

    // A new result is produced only while the sequencer is past the idle step.
    `SKOF_ASSERT_SAME(a_result_while_busy, $rose(out_valid), in_stall, "result outside of a request")

endmodule

bind scalar_kalman_outlier_filter_unit skof_checker u_skof_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered     (filtered),
    .outlier_reset(outlier_reset),
    .gain         (gain)
);

`default_nettype wire

@@ verif/tb_scalar_kalman_outlier_filter_unit.sv @@
// Self-checking testbench for scalar_kalman_outlier_filter_unit.
// A behavioral model of the fixed-point Kalman filter predicts each result;
// depends on skof_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_scalar_kalman_outlier_filter_unit;

    localparam int SAMPLE_BITS   = 16;
    localparam int EST_BITS      = SAMPLE_BITS + 8;
    localparam int REG_COUNT     = 5;
    localparam int INDEX_SPAN    = 1 << skof_pkg::CFG_INDEX_WIDTH;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;

    typedef struct {
        logic [skof_pkg::OUT_WIDTH-1:0] filtered;
        logic                           outlier_reset;
        logic [skof_pkg::GAIN_BITS-1:0] gain;
    } filter_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [skof_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [skof_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [SAMPLE_BITS-1:0]               sample = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [skof_pkg::OUT_WIDTH-1:0]       filtered;
    logic                                 outlier_reset;
    logic [skof_pkg::GAIN_BITS-1:0]       gain;

    scalar_kalman_outlier_filter_unit #(
        .SAMPLE_WIDTH(SAMPLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered     (filtered),
        .outlier_reset(outlier_reset),
        .gain         (gain)
    );

    // Configuration as the model sees it.
    logic [skof_pkg::COV_WIDTH-1:0] cfg_process_variance     = skof_pkg::PV_RESET;
    logic [skof_pkg::COV_WIDTH-1:0] cfg_measurement_variance = skof_pkg::MV_RESET;
    logic [15:0]                    cfg_initial_estimate     = '0;
    logic [skof_pkg::COV_WIDTH-1:0] cfg_initial_covariance   = skof_pkg::COV_RESET;
    logic [skof_pkg::PCT_WIDTH-1:0] cfg_outlier_percent      = skof_pkg::PCT_RESET;

    // Filter state as the model sees it.
    logic [EST_BITS-1:0]            model_estimate   = '0;
    logic [skof_pkg::COV_WIDTH-1:0] model_covariance = '0;
    logic                           model_seeded     = 1'b0;

    filter_result_t pending_results[$];
    filter_result_t due;

    // Idle behavior of each side, chosen per phase.
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;

    int failures        = 0;
    int results_checked = 0;
    int outliers_seen   = 0;
    int settings_used   = 0;
    int cycles          = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Run one filter step on the model and return the result it produces.
    function automatic filter_result_t kalman_step(input logic [SAMPLE_BITS-1:0] reading);
        logic [63:0] pc;
        logic [63:0] den;
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] est;
        logic [63:0] dev;
        logic [63:0] filt;
        logic        hit;
        filter_result_t r;
        if (!model_seeded) begin
            model_estimate   = EST_BITS'({cfg_initial_estimate, 8'd0});
            model_covariance = cfg_initial_covariance;
            model_seeded     = 1'b1;
        end
        // Predicted covariance saturates at the top of its range.
        pc = 64'(model_covariance) + 64'(cfg_process_variance);
        if (pc > 64'hFFFF_FFFF)
            pc = 64'hFFFF_FFFF;
        den = pc + 64'(cfg_measurement_variance);
        k = (den == 64'd0) ? 64'd0 : (pc << 16) / den;
        model_covariance = skof_pkg::COV_WIDTH'(((64'(skof_pkg::GAIN_ONE) - k) * pc) >> 16);
        // Move the estimate toward the reading; the downward step rounds up.
        x   = 64'(reading) << 8;
        est = 64'(model_estimate);
        if (x >= est)
            est = est + ((k * (x - est)) >> 16);
        else
            est = est - ((k * (est - x) + 64'hFFFF) >> 16);
        est = est & ((64'd1 << EST_BITS) - 64'd1);
        filt = (est + 64'd128) >> 8;
        if (filt > 64'hFFFF)
            filt = 64'hFFFF;
        // Relative deviation by cross-multiplication.
        dev = (est >= x) ? est - x : x - est;
        hit = (dev * 64'(skof_pkg::PCT_SCALE)) > (64'(cfg_outlier_percent) * x);
        if (hit) begin
            est  = x;
            filt = 64'(reading);
        end
        model_estimate  = EST_BITS'(est);
        r.filtered      = skof_pkg::OUT_WIDTH'(filt);
        r.outlier_reset = hit;
        r.gain          = skof_pkg::GAIN_BITS'(k);
        return r;
    endfunction

    // Write one register and mirror it into the model.
    task automatic write_register(input logic [skof_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  input logic [skof_pkg::CFG_DATA_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            skof_pkg::REG_PROCESS_VARIANCE:     cfg_process_variance     = value;
            skof_pkg::REG_MEASUREMENT_VARIANCE: cfg_measurement_variance = value;
            skof_pkg::REG_INITIAL_ESTIMATE:     cfg_initial_estimate     = value[15:0];
            skof_pkg::REG_INITIAL_COVARIANCE:   cfg_initial_covariance   = value;
            skof_pkg::REG_OUTLIER_PERCENT:
                cfg_outlier_percent = value[skof_pkg::PCT_WIDTH-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Send one request and record the result it must produce.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(kalman_step(value));
    endtask

    // Stop sending and wait until the unit has returned every result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Variances drawn from the extremes, small values and the full range.
    function automatic logic [31:0] pick_variance();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 65535));
            3: return 32'($urandom_range(0, 1 << 22));
            default: return $urandom;
        endcase
    endfunction

    // Seeding from configuration, with a covariance that saturates at once.
    task automatic test_seeding();
        write_register(skof_pkg::REG_INITIAL_ESTIMATE, 32'h0000_6480);
        write_register(skof_pkg::REG_INITIAL_COVARIANCE, 32'hFFFF_FFFF);
        settings_used++;
        send_sample(16'h6400);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h8000);
        wait_idle();
    endtask

    // Unity gain with no measurement noise, then a zero gain denominator,
    // and zero readings with and without deviation.
    task automatic test_gain_limits();
        write_register(skof_pkg::REG_PROCESS_VARIANCE, 32'd0);
        write_register(skof_pkg::REG_MEASUREMENT_VARIANCE, 32'd0);
        settings_used++;
        send_sample(16'h1234);
        send_sample(16'h1234);
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        wait_idle();
    endtask

    // Largest variances and the outlier threshold at zero, 100 and above 100.
    task automatic test_threshold_extremes();
        write_register(skof_pkg::REG_PROCESS_VARIANCE, 32'hFFFF_FFFF);
        write_register(skof_pkg::REG_MEASUREMENT_VARIANCE, 32'hFFFF_FFFF);
        write_register(skof_pkg::REG_OUTLIER_PERCENT, 32'd127);
        settings_used++;
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h7F7F);
        wait_idle();
        write_register(skof_pkg::REG_OUTLIER_PERCENT, 32'd0);
        settings_used++;
        send_sample(16'h4000);
        send_sample(16'h4001);
        wait_idle();
        write_register(skof_pkg::REG_OUTLIER_PERCENT, 32'd100);
        settings_used++;
        send_sample(16'h0100);
        send_sample(16'hFF00);
        wait_idle();
    endtask

    // Seed values written after the first request must not reach the state,
    // and writes to unused indexes must change nothing.
    task automatic test_late_config();
        for (int i = REG_COUNT; i < INDEX_SPAN; i++)
            write_register(skof_pkg::CFG_INDEX_WIDTH'(i), 32'hFFFF_FFFF);
        write_register(skof_pkg::REG_INITIAL_ESTIMATE, 32'hFFFF_FFFF);
        write_register(skof_pkg::REG_INITIAL_COVARIANCE, 32'd0);
        write_register(skof_pkg::REG_PROCESS_VARIANCE, 32'(skof_pkg::PV_RESET));
        write_register(skof_pkg::REG_MEASUREMENT_VARIANCE, 32'(skof_pkg::MV_RESET));
        write_register(skof_pkg::REG_OUTLIER_PERCENT, 32'(skof_pkg::PCT_RESET));
        settings_used++;
        send_sample(16'h2000);
        send_sample(16'h2000);
        send_sample(16'h2000);
        wait_idle();
    endtask

    // Slowly drifting readings with noise, level steps and stray values,
    // under a fresh random configuration in each phase.
    task automatic test_random_tracking();
        int level;
        int spread;
        int value;
        int pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_register(skof_pkg::REG_PROCESS_VARIANCE, pick_variance());
            write_register(skof_pkg::REG_MEASUREMENT_VARIANCE, pick_variance());
            write_register(skof_pkg::REG_INITIAL_ESTIMATE, $urandom);
            write_register(skof_pkg::REG_INITIAL_COVARIANCE, $urandom);
            if ($urandom_range(0, 2) == 0)
                write_register(skof_pkg::REG_OUTLIER_PERCENT,
                               32'($urandom_range(0, 127)));
            else
                write_register(skof_pkg::REG_OUTLIER_PERCENT,
                               32'($urandom_range(2, 40)));
            settings_used++;
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            level  = $urandom_range(0, 65535);
            spread = 1 << $urandom_range(0, 10);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    level = level + $urandom_range(0, 8) - 4;
                    value = level + $urandom_range(0, 2 * spread) - spread;
                end else if (pick < 90) begin
                    level = $urandom_range(0, 65535);
                    value = level;
                end else if (pick < 95) begin
                    value = $urandom_range(0, 65535);
                end else begin
                    value = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                end
                if (level < 0)
                    level = 0;
                if (level > 65535)
                    level = 65535;
                if (value < 0)
                    value = 0;
                if (value > 65535)
                    value = 65535;
                send_sample(SAMPLE_BITS'(value));
            end
            wait_idle();
        end
    endtask

    // Receiver: stall for a random number of cycles before each result.
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            gap = recv_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: filtered %h", filtered);
                failures++;
            end else begin
                due = pending_results.pop_front();
                results_checked++;
                if (outlier_reset === 1'b1)
                    outliers_seen++;
                if (filtered !== due.filtered) begin
                    $error("filtered: expected %h, got %h", due.filtered, filtered);
                    failures++;
                end
                if (outlier_reset !== due.outlier_reset) begin
                    $error("outlier_reset: expected %b, got %b",
                           due.outlier_reset, outlier_reset);
                    failures++;
                end
                if (gain !== due.gain) begin
                    $error("gain: expected %h, got %h", due.gain, gain);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_seeding();
        test_gain_limits();
        test_threshold_extremes();
        test_late_config();
        test_random_tracking();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end
        $display("Checked %0d filtered readings (%0d outlier resets) under %0d settings.",
                 results_checked, outliers_seen, settings_used);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/skof_pkg.sv
rtl/skof_mul.sv
rtl/skof_dp.sv
rtl/skof_seq.sv
rtl/scalar_kalman_outlier_filter_unit.sv
rtl/skof_checker.sv
verif/tb_scalar_kalman_outlier_filter_unit.sv
